/* rtl/mrpn_pkg.sv */
// Shared types, constants and opcodes of the memory region page navigator.
`timescale 1ns / 1ps
`default_nettype none
package mrpn_pkg;
  localparam int NumRegions = 16;
  localparam int SlotW = 4;
  localparam int CountW = 5;
  localparam int RegionPageShift = 12;
  localparam int PagesW = 52;
  localparam int KindW = 4;
  localparam int AddrW = 64;
  localparam int LogW = 6;
  localparam int MaskW = 16;

  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_ADDR  = 3'd1,
    OP_RANGE = 3'd2,
    OP_FIRST = 3'd3,
    OP_NEXT  = 3'd4,
    OP_PREV  = 3'd5,
    OP_NOP6  = 3'd6,
    OP_NOP7  = 3'd7
  } op_t;

  typedef enum logic [1:0] {
    REG_COUNT = 2'd0,
    REG_LOG2  = 2'd1,
    REG_MASK  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_PROBE = 2'd1,
    ST_SCAN  = 2'd2,
    ST_DONE  = 2'd3
  } state_t;

  // One descriptor moving along the cell chain.
  typedef struct packed {
    logic [AddrW-1:0]  start;
    logic [PagesW-1:0] pages;
    logic [KindW-1:0]  kind;
  } desc_t;
endpackage
`default_nettype wire

/* rtl/memory_region_page_navigator_unit.sv */
// Top level: descriptor cell ring, query sequencer and result register.
//
//  channel | ports                                          | timing
//  cmd     | start, busy, opcode, slot, address, length,    | taken when start & !busy
//          |   region_type                                  |
//  result  | done, found, result_address                    | one-cycle strobe
//  config  | cfg_we, cfg_index, cfg_data                    | written on any clk edge with cfg_we high
//
// A load writes its cell and passes through the done state. Queries rotate the
// 16-cell ring once per pass, one descriptor per cycle into the evaluator;
// next/previous page queries make a probe pass and, if it misses, a scan pass.
// Synchronous reset clears the control state and config registers; the query
// operands and descriptor cells hold no reset. The result strobe cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module memory_region_page_navigator_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [2:0]  opcode,
  input  wire logic [3:0]  slot,
  input  wire logic [63:0] address,
  input  wire logic [63:0] length,
  input  wire logic [3:0]  region_type,
  output logic             done,
  output logic             found,
  output logic [63:0]      result_address,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int N  = mrpn_pkg::NumRegions;
  localparam int AW = mrpn_pkg::AddrW;
  localparam int CW = mrpn_pkg::CountW;

  mrpn_pkg::state_t state, state_next;
  mrpn_pkg::op_t    op;
  logic [CW-1:0] region_count, step;
  logic [mrpn_pkg::LogW-1:0]  view_page_log2;
  logic [mrpn_pkg::MaskW-1:0] browsable_type_mask;
  logic [AW-1:0] qa, qend, cur, nxt, prv, ps, best, pg;
  logic          acc, bad_range, have;
  mrpn_pkg::desc_t cells [N];
  mrpn_pkg::desc_t ld;
  logic rotate, load_go;
  logic [CW-1:0] used;
  logic          last_step, active;

  logic brows, h_a, h_r, h_p, n_ok, p_ok;
  logic [AW-1:0] n_c, p_c;

  assign ld = '{start: address, pages: length[mrpn_pkg::PagesW-1:0], kind: region_type};
  assign load_go = start && !busy && mrpn_pkg::op_t'(opcode) == mrpn_pkg::OP_LOAD;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      mrpn_cell u_cell (
        .clk(clk), .load(load_go && slot == mrpn_pkg::SlotW'(g)), .load_desc(ld),
        .rotate(rotate), .prev_desc(cells[(g + 1) % N]), .desc(cells[g])
      );
    end
  endgenerate

  // probe the page after the current one for next, the one before for previous
  assign pg = (op == mrpn_pkg::OP_NEXT) ? nxt : prv;

  mrpn_eval u_eval (
    .desc(cells[0]), .mask(browsable_type_mask), .ps(ps), .qa(qa), .qend(qend),
    .cur(cur), .nxt(nxt), .prv(pg), .brows(brows), .hit_addr(h_a),
    .hit_range(h_r), .hit_page(h_p), .nxt_ok(n_ok), .nxt_cand(n_c),
    .prv_ok(p_ok), .prv_cand(p_c)
  );

  assign used      = (region_count > CW'(N)) ? CW'(N) : region_count;
  assign active    = step < used;
  assign last_step = step == CW'(N - 1);
  assign busy      = state != mrpn_pkg::ST_IDLE;

  // advance through all N cells every pass so the ring returns home
  always_comb begin
    rotate = state == mrpn_pkg::ST_PROBE || state == mrpn_pkg::ST_SCAN;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      mrpn_pkg::ST_IDLE: begin
        if (start) begin
          unique case (mrpn_pkg::op_t'(opcode))
            mrpn_pkg::OP_ADDR, mrpn_pkg::OP_RANGE, mrpn_pkg::OP_FIRST,
            mrpn_pkg::OP_NEXT, mrpn_pkg::OP_PREV: state_next = mrpn_pkg::ST_PROBE;
            default: state_next = mrpn_pkg::ST_DONE;
          endcase
        end
      end
      mrpn_pkg::ST_PROBE: begin
        if (last_step) begin
          if ((op == mrpn_pkg::OP_NEXT || op == mrpn_pkg::OP_PREV) && !acc && !have) begin
            state_next = mrpn_pkg::ST_SCAN;
          end else begin
            state_next = mrpn_pkg::ST_DONE;
          end
        end
      end
      mrpn_pkg::ST_SCAN: if (last_step) state_next = mrpn_pkg::ST_DONE;
      mrpn_pkg::ST_DONE: state_next = mrpn_pkg::ST_IDLE;
      default: state_next = mrpn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    done           = state == mrpn_pkg::ST_DONE;
    found          = 1'b0;
    result_address = '0;
    if (done) begin
      unique case (op)
        mrpn_pkg::OP_ADDR: found = acc;
        mrpn_pkg::OP_RANGE: found = acc && !bad_range;
        mrpn_pkg::OP_FIRST: result_address = acc ? best : '0;
        // for next and previous page, best==0 means none yet; cur substitutes at the end
        mrpn_pkg::OP_NEXT: result_address = have ? cur
                                          : (acc ? nxt : (best != '0 ? best : cur));
        mrpn_pkg::OP_PREV: result_address = have ? cur
                                          : (acc ? prv : (best != '0 ? best : cur));
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= mrpn_pkg::ST_IDLE;
      region_count        <= '0;
      view_page_log2      <= mrpn_pkg::LogW'(12);
      browsable_type_mask <= mrpn_pkg::MaskW'(3838);
      step                <= '0;
      acc                 <= 1'b0;
      have                <= 1'b0;
      op                  <= mrpn_pkg::OP_NOP7;
      bad_range           <= 1'b0;
      best                <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (mrpn_pkg::reg_idx_t'(cfg_index))
          mrpn_pkg::REG_COUNT: region_count <= cfg_data[CW-1:0];
          mrpn_pkg::REG_LOG2:  view_page_log2 <= cfg_data[mrpn_pkg::LogW-1:0];
          mrpn_pkg::REG_MASK:  browsable_type_mask <= cfg_data;
          default: ;
        endcase
      end
      if (state == mrpn_pkg::ST_IDLE && start) begin
        op   <= mrpn_pkg::op_t'(opcode);
        step <= '0;
        acc  <= 1'b0;
        best <= '0;
        qa   <= address;
        qend <= address + length;
        bad_range <= length == '0 || address > ~length;
        ps  <= AW'(1) << view_page_log2;
        cur <= address & ~((AW'(1) << view_page_log2) - AW'(1));
        nxt <= (address & ~((AW'(1) << view_page_log2) - AW'(1)))
               + (AW'(1) << view_page_log2);
        prv <= (address & ~((AW'(1) << view_page_log2) - AW'(1)))
               - (AW'(1) << view_page_log2);
        // early exits: top page for next, bottom for previous
        unique case (mrpn_pkg::op_t'(opcode))
          mrpn_pkg::OP_NEXT:
            have <= (address & ~((AW'(1) << view_page_log2) - AW'(1)))
                    > ~(AW'(1) << view_page_log2) + AW'(1) - AW'(1);
          mrpn_pkg::OP_PREV:
            have <= (address & ~((AW'(1) << view_page_log2) - AW'(1)))
                    < (AW'(1) << view_page_log2);
          default: have <= 1'b0;
        endcase
      end else if (rotate) begin
        step <= last_step ? '0 : step + CW'(1);
        if (state == mrpn_pkg::ST_PROBE && active) begin
          unique case (op)
            mrpn_pkg::OP_ADDR:  if (h_a) acc <= 1'b1;
            mrpn_pkg::OP_RANGE: if (h_r) acc <= 1'b1;
            mrpn_pkg::OP_FIRST: if (brows && !acc) begin
              acc  <= 1'b1;
              best <= cells[0].start;
            end
            mrpn_pkg::OP_NEXT, mrpn_pkg::OP_PREV: if (h_p) acc <= 1'b1;
            default: ;
          endcase
        end
        if (state == mrpn_pkg::ST_SCAN && active) begin
          if (op == mrpn_pkg::OP_NEXT) begin
            if (n_ok && (best == '0 || n_c < best)) best <= n_c;
          end else begin
            if (p_ok && p_c > best) best <= p_c;
          end
        end
      end
      if (state == mrpn_pkg::ST_PROBE && last_step && op == mrpn_pkg::OP_NEXT
          && !acc && !have) begin
        best <= '0;
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/mrpn_cell.sv */
// One table cell: holds a descriptor and shifts it toward its neighbor on rotate.
`timescale 1ns / 1ps
`default_nettype none
module mrpn_cell (
  input  wire logic           clk,
  input  wire logic           load,
  input  wire mrpn_pkg::desc_t load_desc,
  input  wire logic           rotate,
  input  wire mrpn_pkg::desc_t prev_desc,
  output mrpn_pkg::desc_t     desc
);
  always_ff @(posedge clk) begin
    if (load) begin
      desc <= load_desc;
    end else if (rotate) begin
      desc <= prev_desc;
    end
  end
endmodule
`default_nettype wire

/* rtl/mrpn_eval.sv */
// Per-descriptor evaluation for checks and next/previous page candidates.
`timescale 1ns / 1ps
`default_nettype none
module mrpn_eval (
  input  wire mrpn_pkg::desc_t           desc,
  input  wire logic [mrpn_pkg::MaskW-1:0] mask,
  input  wire logic [mrpn_pkg::AddrW-1:0] ps,
  input  wire logic [mrpn_pkg::AddrW-1:0] qa,
  input  wire logic [mrpn_pkg::AddrW-1:0] qend,
  input  wire logic [mrpn_pkg::AddrW-1:0] cur,
  input  wire logic [mrpn_pkg::AddrW-1:0] nxt,
  input  wire logic [mrpn_pkg::AddrW-1:0] prv,
  output logic                           brows,
  output logic                           hit_addr,
  output logic                           hit_range,
  output logic                           hit_page,
  output logic                           nxt_ok,
  output logic [mrpn_pkg::AddrW-1:0]      nxt_cand,
  output logic                           prv_ok,
  output logic [mrpn_pkg::AddrW-1:0]      prv_cand
);
  localparam int AW = mrpn_pkg::AddrW;
  logic [AW-1:0] size, endw, pm, first, last, upn, pend;
  logic [AW:0]   sum;
  logic          nz, ovf, geom;

  always_comb begin
    brows = mask[desc.kind];
    size  = {desc.pages, {mrpn_pkg::RegionPageShift{1'b0}}};
    nz    = desc.pages != '0;
    sum   = {1'b0, desc.start} + {1'b0, size};
    ovf   = sum[AW];
    endw  = sum[AW-1:0];
    pm    = ps - AW'(1);
    first = (desc.start + pm) & ~pm;
    // page end may wrap past the top of the address space
    pend  = prv + ps;
    // checks: zero pages gives empty region, overflow skips it
    hit_addr  = brows && nz && !ovf && qa >= desc.start && qa < endw;
    hit_range = brows && nz && !ovf && qa >= desc.start && qend <= endw;
    hit_page  = brows && nz && !ovf && prv >= desc.start && pend <= endw;
    geom = brows && nz && !(endw < ps) && !((first + ps) > endw);
    last = (endw - ps) & ~pm;
    upn  = (nxt + pm) & ~pm;
    nxt_ok   = 1'b0;
    nxt_cand = first;
    if (geom) begin
      if (nxt <= first) begin
        nxt_ok = 1'b1;
      end else if (nxt < endw) begin
        nxt_cand = upn;
        nxt_ok   = !((upn + ps) > endw);
      end
    end
    if (nxt_ok && !(nxt_cand > cur)) nxt_ok = 1'b0;
    prv_ok   = 1'b0;
    prv_cand = last;
    if (geom && !(last < first) && cur > first) begin
      if (cur > last) begin
        prv_ok = 1'b1;
      end else begin
        prv_cand = cur - ps;
        prv_ok   = !(prv_cand < first);
      end
    end
    if (prv_ok && !(prv_cand < cur)) prv_ok = 1'b0;
  end
endmodule
`default_nettype wire

/* dv/tb_memory_region_page_navigator_unit.sv */
// Testbench for the memory region page navigator: directed and random queries.
`timescale 1ns / 1ps
module tb_memory_region_page_navigator_unit;

  typedef struct packed {
    logic        found;
    logic [63:0] addr;
  } answer_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [2:0]  opcode;
  logic [3:0]  slot;
  logic [63:0] address;
  logic [63:0] length;
  logic [3:0]  region_type;
  logic        done;
  logic        found;
  logic [63:0] result_address;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  memory_region_page_navigator_unit i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode), .slot(slot),
    .address(address), .length(length), .region_type(region_type), .done(done),
    .found(found), .result_address(result_address), .cfg_we(cfg_we),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predictor copy of the table and registers
  logic [63:0]     tbl_start [mrpn_pkg::NumRegions];
  logic [51:0]     tbl_pages [mrpn_pkg::NumRegions];
  logic [3:0]      tbl_kind  [mrpn_pkg::NumRegions];
  logic [4:0]      cur_count;
  logic [5:0]      cur_log2;
  logic [15:0]     cur_mask;
  answer_t         pending_answers[$];
  int              mismatch_count;
  int              answers_seen;
  int              items_sent;
  localparam logic [63:0] Ones = '1;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch: %s got %h expected %h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // check each result word against the oldest prediction
  always @(posedge clk) begin
    answer_t want;
    if (!rst && done) begin
      answers_seen++;
      if (pending_answers.size() == 0) begin
        report("unexpected word", {found, result_address[62:0]}, 0);
      end else begin
        want = pending_answers.pop_front();
        if (found !== want.found) report("found", found, want.found);
        if (result_address !== want.addr) report("result_address", result_address, want.addr);
      end
    end
  end

  function automatic int used_regions();
    return cur_count > mrpn_pkg::NumRegions ? mrpn_pkg::NumRegions : cur_count;
  endfunction

  function automatic bit is_browsable(int i);
    return cur_mask[tbl_kind[i]];
  endfunction

  function automatic bit region_end_ok(int i, output logic [63:0] e);
    logic [63:0] sz;
    sz = {tbl_pages[i], 12'b0};
    e = tbl_start[i];
    if (tbl_pages[i] == 0) return 1;
    if (sz > 0 && tbl_start[i] > Ones - sz) return 0;
    e = tbl_start[i] + sz;
    return 1;
  endfunction

  function automatic bit addr_hit(logic [63:0] a);
    logic [63:0] e;
    for (int i = 0; i < used_regions(); i++)
      if (is_browsable(i) && region_end_ok(i, e) && a >= tbl_start[i] && a < e) return 1;
    return 0;
  endfunction

  function automatic bit range_hit(logic [63:0] a, logic [63:0] len);
    logic [63:0] e;
    if (len == 0 || a > Ones - len) return 0;
    for (int i = 0; i < used_regions(); i++)
      if (is_browsable(i) && region_end_ok(i, e) && a >= tbl_start[i] && a + len <= e)
        return 1;
    return 0;
  endfunction

  function automatic bit page_hit(logic [63:0] a, logic [63:0] ps);
    logic [63:0] b, e;
    b = a & ~(ps - 1);
    for (int i = 0; i < used_regions(); i++)
      if (is_browsable(i) && tbl_pages[i] != 0 && region_end_ok(i, e) &&
          b >= tbl_start[i] && b + ps <= e) return 1;
    return 0;
  endfunction

  function automatic logic [63:0] round_up(logic [63:0] a, logic [63:0] ps);
    return (a + (ps - 1)) & ~(ps - 1);
  endfunction

  function automatic logic [63:0] step_forward(logic [63:0] a, logic [63:0] ps);
    logic [63:0] cur, nxt, best, e, first, cand;
    cur = a & ~(ps - 1);
    if (cur > Ones - ps) return cur;
    nxt = cur + ps;
    if (page_hit(nxt, ps)) return nxt;
    best = cur;
    for (int i = 0; i < used_regions(); i++) begin
      if (!is_browsable(i) || tbl_pages[i] == 0) continue;
      e = tbl_start[i] + {tbl_pages[i], 12'b0};
      first = round_up(tbl_start[i], ps);
      if (e < ps || first + ps > e) continue;
      if (nxt <= first) cand = first;
      else if (nxt < e) begin
        cand = round_up(nxt, ps);
        if (cand + ps > e) continue;
      end else continue;
      if (cand > cur && (best == cur || cand < best)) best = cand;
    end
    return best;
  endfunction

  function automatic logic [63:0] step_back(logic [63:0] a, logic [63:0] ps);
    logic [63:0] cur, prv, best, e, first, last, cand;
    if (a == 0) return 0;
    cur = a & ~(ps - 1);
    if (cur < ps) return cur;
    prv = cur - ps;
    if (page_hit(prv, ps)) return prv;
    best = 0;
    for (int i = 0; i < used_regions(); i++) begin
      if (!is_browsable(i) || tbl_pages[i] == 0) continue;
      e = tbl_start[i] + {tbl_pages[i], 12'b0};
      first = round_up(tbl_start[i], ps);
      if (e < ps || first + ps > e) continue;
      last = (e - ps) & ~(ps - 1);
      if (last < first || cur <= first) continue;
      if (cur > last) cand = last;
      else begin
        cand = cur - ps;
        if (cand < first) continue;
      end
      if (cand < cur && cand > best) best = cand;
    end
    return best != 0 ? best : cur;
  endfunction

  function automatic answer_t navigate(mrpn_pkg::op_t op, logic [3:0] s, logic [63:0] a,
                                       logic [63:0] len, logic [3:0] k);
    answer_t r;
    logic [63:0] ps;
    r = '0;
    ps = 64'd1 << cur_log2;
    case (op)
      mrpn_pkg::OP_LOAD: begin
        tbl_start[s] = a;
        tbl_pages[s] = len[51:0];
        tbl_kind[s] = k;
      end
      mrpn_pkg::OP_ADDR:  r.found = addr_hit(a);
      mrpn_pkg::OP_RANGE: r.found = range_hit(a, len);
      mrpn_pkg::OP_FIRST: begin
        for (int i = 0; i < used_regions(); i++)
          if (is_browsable(i)) begin
            r.addr = tbl_start[i];
            break;
          end
      end
      mrpn_pkg::OP_NEXT:  r.addr = step_forward(a, ps);
      mrpn_pkg::OP_PREV:  r.addr = step_back(a, ps);
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(mrpn_pkg::op_t op, logic [3:0] s, logic [63:0] a, logic [63:0] len,
                           logic [3:0] k);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 13);
    repeat (gap) @(negedge clk);
    start <= 1; opcode <= op; slot <= s; address <= a; length <= len; region_type <= k;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_answers.push_back(navigate(op, s, a, len, k));
    items_sent++;
    @(negedge clk);
    // drop start and scramble the idle opcode, slot and address
    start = 0;
    opcode = 3'($urandom); slot = 4'($urandom); address = {$urandom, $urandom};
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    while (pending_answers.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(mrpn_pkg::reg_idx_t idx, logic [15:0] v);
    drain();
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_we <= 0;
    case (idx)
      mrpn_pkg::REG_COUNT: cur_count = v[4:0];
      mrpn_pkg::REG_LOG2:  cur_log2 = v[5:0];
      mrpn_pkg::REG_MASK:  cur_mask = v;
      default: ;
    endcase
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // address near a region start or end, near the top or bottom of the space, or random
  function automatic logic [63:0] near_addr();
    int i;
    logic [63:0] b;
    i = $urandom_range(0, mrpn_pkg::NumRegions - 1);
    case ($urandom_range(0, 4))
      0: return rand64();
      1: b = tbl_start[i];
      2: b = tbl_start[i] + {tbl_pages[i], 12'b0};
      3: return Ones - $urandom_range(0, 1 << 14);
      default: return $urandom_range(0, 1 << 16);
    endcase
    return b + $signed($urandom_range(0, 1 << 14)) - 64'd8192;
  endfunction

  function automatic logic [63:0] pick_pages();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return rand64();
      2: return Ones;
      default: return $urandom_range(1, 64);
    endcase
  endfunction

  function automatic logic [63:0] pick_start();
    case ($urandom_range(0, 4))
      0: return rand64();
      1: return Ones - $urandom_range(0, 1 << 16);
      2: return {$urandom_range(0, 255), 12'h000} + $urandom_range(0, 1) * $urandom_range(0, 4095);
      default: return {$urandom_range(0, 1 << 10), 16'h0} + {$urandom_range(0, 15), 12'h0};
    endcase
  endfunction

  task automatic load_table(int cnt);
    for (int i = 0; i < cnt; i++)
      send_item(mrpn_pkg::OP_LOAD, 4'(i), pick_start(), pick_pages(), 4'($urandom));
  endtask

  task automatic test_directed();
    load_table(mrpn_pkg::NumRegions);
    write_reg(mrpn_pkg::REG_COUNT, 0);
    send_item(mrpn_pkg::OP_FIRST, 0, 0, 0, 0);
    send_item(mrpn_pkg::OP_NEXT, 0, 64'h5000, 0, 0);
    write_reg(mrpn_pkg::REG_COUNT, 31);
    write_reg(mrpn_pkg::REG_MASK, 16'hffff);
    send_item(mrpn_pkg::OP_LOAD, 0, 64'h1000, 4, 1);
    send_item(mrpn_pkg::OP_LOAD, 1, Ones - 64'h0fff, 2, 2);
    send_item(mrpn_pkg::OP_LOAD, 2, 64'h20000, 0, 3);
    send_item(mrpn_pkg::OP_LOAD, 3, 64'hffff_ffff_ffff_e000, 2, 15);
    send_item(mrpn_pkg::OP_ADDR, 0, 64'h1000, 0, 0);
    send_item(mrpn_pkg::OP_ADDR, 0, 64'h4fff, 0, 0);
    send_item(mrpn_pkg::OP_ADDR, 0, 64'h5000, 0, 0);
    send_item(mrpn_pkg::OP_ADDR, 0, Ones, 0, 0);
    send_item(mrpn_pkg::OP_RANGE, 0, 64'h1000, 0, 0);
    send_item(mrpn_pkg::OP_RANGE, 0, 64'h1000, 64'h4000, 0);
    send_item(mrpn_pkg::OP_RANGE, 0, Ones, Ones, 0);
    send_item(mrpn_pkg::OP_FIRST, 0, 0, 0, 0);
    send_item(mrpn_pkg::OP_NEXT, 0, Ones, 0, 0);
    send_item(mrpn_pkg::OP_NEXT, 0, 64'h4000, 0, 0);
    send_item(mrpn_pkg::OP_PREV, 0, 0, 0, 0);
    send_item(mrpn_pkg::OP_PREV, 0, 64'h0fff, 0, 0);
    send_item(mrpn_pkg::OP_PREV, 0, 64'h30000, 0, 0);
    send_item(mrpn_pkg::OP_NOP6, 5, Ones, Ones, 15);
    send_item(mrpn_pkg::OP_NOP7, 9, 0, 0, 0);
    write_reg(mrpn_pkg::REG_LOG2, 63);
    send_item(mrpn_pkg::OP_NEXT, 0, 64'h8000_0000_0000_0000, 0, 0);
    send_item(mrpn_pkg::OP_PREV, 0, Ones, 0, 0);
    write_reg(mrpn_pkg::REG_LOG2, 0);
    send_item(mrpn_pkg::OP_NEXT, 0, 64'h1000, 0, 0);
    send_item(mrpn_pkg::OP_PREV, 0, 64'h1003, 0, 0);
    write_reg(mrpn_pkg::REG_MASK, 0);
    send_item(mrpn_pkg::OP_FIRST, 0, 0, 0, 0);
  endtask

  task automatic test_random(int total);
    mrpn_pkg::op_t op;
    int n;
    n = 0;
    while (n < total) begin
      if (n % 150 == 0) begin
        write_reg(mrpn_pkg::REG_COUNT, 16'($urandom_range(0, 3) == 0 ? $urandom_range(17, 31) :
                  $urandom_range(0, mrpn_pkg::NumRegions)));
        write_reg(mrpn_pkg::REG_LOG2, 16'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63) :
                  $urandom_range(10, 16)));
        write_reg(mrpn_pkg::REG_MASK, 16'($urandom_range(0, 3) == 0 ? $urandom :
                  16'h0efe | $urandom));
        load_table(mrpn_pkg::NumRegions);
        n += mrpn_pkg::NumRegions;
      end
      op = mrpn_pkg::op_t'($urandom_range(0, 9) == 0 ? $urandom_range(0, 7) :
                           $urandom_range(1, 5));
      if (op == mrpn_pkg::OP_LOAD)
        send_item(op, 4'($urandom), pick_start(), pick_pages(), 4'($urandom));
      else
        send_item(op, 4'($urandom), near_addr(),
                  $urandom_range(0, 1) ? rand64() : $urandom_range(0, 1 << 15), 4'($urandom));
      n++;
    end
  endtask

  initial begin
    rst = 1; start = 0; opcode = 0; slot = 0; address = 0; length = 0; region_type = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    cur_count = 0; cur_log2 = 12; cur_mask = 16'd3838;
    mismatch_count = 0; answers_seen = 0; items_sent = 0;
    for (int i = 0; i < mrpn_pkg::NumRegions; i++) begin
      tbl_start[i] = 0; tbl_pages[i] = 0; tbl_kind[i] = 0;
    end
    repeat (7) @(negedge clk);
    rst = 0;
    test_directed();
    test_random(1800);
    drain();
    $display("covered %0d items and %0d result words over loads, checks, first,", items_sent,
             answers_seen);
    $display("next and previous page queries with several counts, page sizes and masks");
    if (mismatch_count == 0 && pending_answers.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("simulation failed");
    $finish;
  end
endmodule

/* files.f */
rtl/mrpn_pkg.sv
rtl/mrpn_cell.sv
rtl/mrpn_eval.sv
rtl/memory_region_page_navigator_unit.sv
dv/tb_memory_region_page_navigator_unit.sv
